// ----- design/hec_pkg.sv -----
// Shared constants and types for the Huffman encoder bit packer.
`timescale 1ns / 1ps
package hec_pkg;

    localparam int BYTE_W       = 8;
    localparam int SYM_W        = 8;
    localparam int CODE_W       = 16;
    localparam int LEN_W        = 5;
    localparam int MAX_CODE_LEN = 16;
    localparam int SYMBOL_COUNT = 256;

    // Stored length saturates at the smaller of the code limit and the field width.
    localparam int LEN_CAP_I = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);

    // Table word: length above code.
    localparam int ENTRY_W = LEN_W + CODE_W;

    // Accumulator holds up to seven pending bits plus one full code.
    localparam int PEND_W = BYTE_W - 1;
    localparam int CNT_W  = 3;
    localparam int ACC_W  = PEND_W + CODE_W;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } t_action;

endpackage

// ----- design/huffman_encoder_bit_packer.sv -----
// Top level: Huffman encoder with MSB-first byte packing.
// Usage:
//   Input channel (i_valid/o_ready) carries an action, a symbol, and on load
//   the code bits and code length. Load writes one table entry, encode appends
//   the symbol's code to the bit accumulator, flush pads and emits the partial
//   byte. Output channel (o_valid/i_ready) carries one packed word per
//   transfer; o_last_byte marks the final word caused by an input item.
//   Path: an item's table read is registered with the item, then the pack stage
//   writes its words into the output queue, from which they are offered.
//   Throughput: one item per cycle while the output queue has room, loads
//   included; an encode can make two words, and the single output channel
//   drains the four-entry output queue one word per transfer.
//   Reset: the length table reads as zero through per-entry valid bits that
//   clear at once, the accumulator empties; no clearing pass is needed.
//   Receiver stall: words wait in the output queue; the pack stage holds when
//   fewer than two slots are free, and o_ready drops once it holds.
`timescale 1ns / 1ps
module huffman_encoder_bit_packer
    import hec_pkg::*;
#(
    parameter int SYMBOL_COUNT = hec_pkg::SYMBOL_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [CODE_W-1:0] i_code_bits,
    input  logic [LEN_W-1:0]  i_code_length,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_packed_byte,
    output logic              o_last_byte
);

    localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // Input side
    logic          w_accept;
    logic          w_in_range;
    logic [AW-1:0] w_addr;
    logic [LEN_W-1:0] w_len_cap;
    t_action       w_act;

    logic [SYMBOL_COUNT-1:0] r_vld;
    logic [ENTRY_W-1:0]      w_rdata;

    // Pack stage
    logic          r_s1_valid;
    logic [1:0]    r_s1_action;
    logic          r_s1_lvld;
    logic          w_s1_go;

    logic [PEND_W-1:0] r_pbits, n_pbits;
    logic [CNT_W-1:0]  r_pcnt, n_pcnt;

    logic [LEN_W-1:0]  w_len;
    logic [CODE_W:0]   w_code;
    logic [ACC_W-1:0]  w_acc;
    logic [LEN_W-1:0]  w_total;
    logic [LEN_W-1:0]  w_rem;
    logic [ACC_W-1:0]  w_sh0, w_sh1;
    logic [BYTE_W-1:0] w_flush_byte;

    logic [1:0]        w_np;
    logic [BYTE_W-1:0] w_b0, w_b1;
    logic              w_l0, w_l1;

    // Output queue
    logic [BYTE_W-1:0]   r_oq_byte [OQ_DEPTH];
    logic                r_oq_last [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wptr, r_rptr;
    logic [OQ_CNT_W-1:0] r_oq_cnt;
    logic                w_pop;

    assign w_act      = t_action'(i_action);
    assign w_accept   = i_valid && o_ready;
    assign w_in_range = (int'(i_symbol) < SYMBOL_COUNT);
    assign w_addr     = i_symbol[AW-1:0];
    assign w_len_cap  = (i_code_length > LEN_CAP) ? LEN_CAP : i_code_length;

    hec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_accept && (w_act == ACT_LOAD) && w_in_range),
        .i_re    (w_accept && (w_act == ACT_ENCODE)),
        .i_addr  (w_addr),
        .i_wdata ({w_len_cap, i_code_bits}),
        .o_rdata (w_rdata)
    );

    // Entry valid bits: an entry never loaded reads as length zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_accept && (w_act == ACT_LOAD) && w_in_range) begin
            r_vld[w_addr] <= 1'b1;
        end
    end

    assign w_s1_go = r_s1_valid && (r_oq_cnt <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign o_ready = !r_s1_valid || w_s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_action <= i_action;
            r_s1_lvld   <= w_in_range && r_vld[w_addr];
        end
    end

    // Pack: on encode append the code and cut out up to two finished words; on flush pad the partial byte.
    always_comb begin
        w_len   = r_s1_lvld ? w_rdata[ENTRY_W-1:CODE_W] : '0;
        w_code  = {1'b0, w_rdata[CODE_W-1:0]} & (((CODE_W+1)'(1) << w_len) - (CODE_W+1)'(1));
        w_acc   = (ACC_W'(r_pbits) << w_len) | ACC_W'(w_code);
        w_total = LEN_W'(r_pcnt) + w_len;
        w_sh0   = w_acc >> (w_total - LEN_W'(BYTE_W));
        w_sh1   = w_acc >> (w_total - LEN_W'(2 * BYTE_W));
        w_flush_byte = BYTE_W'({1'b0, r_pbits} << (4'(BYTE_W) - {1'b0, r_pcnt}));

        n_pbits = r_pbits;
        n_pcnt  = r_pcnt;
        w_np    = 2'd0;
        w_b0    = w_sh0[BYTE_W-1:0];
        w_b1    = w_sh1[BYTE_W-1:0];
        w_l0    = 1'b1;
        w_l1    = 1'b1;
        w_rem   = w_total;

        case (t_action'(r_s1_action))
            ACT_ENCODE: begin
                if (w_total >= LEN_W'(2 * BYTE_W)) begin
                    w_np  = 2'd2;
                    w_l0  = 1'b0;
                    w_rem = w_total - LEN_W'(2 * BYTE_W);
                end else if (w_total >= LEN_W'(BYTE_W)) begin
                    w_np  = 2'd1;
                    w_rem = w_total - LEN_W'(BYTE_W);
                end
                n_pcnt  = w_rem[CNT_W-1:0];
                n_pbits = w_acc[PEND_W-1:0]
                        & ((PEND_W'(1) << w_rem[CNT_W-1:0]) - PEND_W'(1));
            end
            ACT_FLUSH: begin
                if (r_pcnt != '0) begin
                    w_np = 2'd1;
                    w_b0 = w_flush_byte;
                end
                n_pbits = '0;
                n_pcnt  = '0;
            end
            default: begin
                // load finished at the table write; hold the accumulator
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits <= '0;
            r_pcnt  <= '0;
        end else if (w_s1_go) begin
            r_pbits <= n_pbits;
            r_pcnt  <= n_pcnt;
        end
    end

    // Output queue
    assign o_valid       = (r_oq_cnt != '0);
    assign w_pop         = o_valid && i_ready;
    assign o_packed_byte = r_oq_byte[r_rptr];
    assign o_last_byte   = r_oq_last[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_s1_go && (w_np != 2'd0)) begin
            r_oq_byte[r_wptr] <= w_b0;
            r_oq_last[r_wptr] <= w_l0;
        end
        if (w_s1_go && (w_np == 2'd2)) begin
            r_oq_byte[r_wptr + OQ_PTR_W'(1)] <= w_b1;
            r_oq_last[r_wptr + OQ_PTR_W'(1)] <= w_l1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (w_s1_go) begin
                r_wptr <= r_wptr + OQ_PTR_W'(w_np);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + OQ_PTR_W'(1);
            end
            r_oq_cnt <= r_oq_cnt + (w_s1_go ? OQ_CNT_W'(w_np) : '0)
                      - OQ_CNT_W'(w_pop);
        end
    end

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue overflow");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && (r_s1_action == ACT_FLUSH)) |=> (r_pcnt == '0))
        else $error("flush left pending bits");

    a_zero_len_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && (r_s1_action == ACT_ENCODE) && (w_len == '0)) |=>
            ((r_pcnt == $past(r_pcnt)) && (r_oq_cnt <= $past(r_oq_cnt))))
        else $error("zero length symbol changed state or emitted");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && (r_s1_action == ACT_LOAD)) |-> (w_np == 2'd0))
        else $error("load produced output");

endmodule

// ----- design/hec_ram.sv -----
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module hec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
